>>> rtl/rllt_pkg.sv
// Package: types, sizes and codes of the run-length line table.
`timescale 1ns / 1ps
`default_nettype none
package rllt_pkg;

  localparam int unsigned CODE_DEPTH = 4096;
  localparam int unsigned RUN_DEPTH  = 4096;
  localparam int unsigned LINE_BITS  = 16;

  localparam int unsigned OFF_W  = $clog2(CODE_DEPTH);
  localparam int unsigned BCNT_W = $clog2(CODE_DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(RUN_DEPTH);
  localparam int unsigned RCNT_W = $clog2(RUN_DEPTH + 1);

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic        op;
    logic [15:0] source_line;
    logic [11:0] code_offset;
  } item_t;

  typedef struct packed {
    logic [15:0] found_line;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic [OFF_W-1:0]     start;
    logic [LINE_BITS-1:0] line;
  } run_t;

endpackage
`default_nettype wire

>>> rtl/run_length_line_table_core.sv
// Top level: run-length line table with a memory-based binary search.
//
// Usage:
//   Drive item_i and raise start; the item is taken at a rising edge with
//   start high and busy low. An append item counts one code byte (unless
//   refused as full) and opens a new run only when its line differs from
//   the last run's line. A lookup item finds the run covering code_offset.
//   Each item yields exactly one result: result_o is shown for one cycle with
//   result_valid_o high. The receiver cannot stall; it takes every result.
//   An append, a refused append and a lookup on an empty table answer in
//   the cycle after acceptance and leave busy low, so these items may
//   follow each other every cycle. A lookup on a non-empty table holds busy
//   while it walks the runs by binary search; its result appears in the
//   cycle in which busy falls. The walk is paced by the run memory: one
//   probe per cycle through its single registered read port, plus a final
//   read of the chosen run's line.
//   Reset clears the byte count and run count; the run memory needs no
//   clearing since only entries below the run count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module run_length_line_table_core (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  input  wire rllt_pkg::item_t item_i,
  output logic               busy,
  output logic               result_valid_o,
  output rllt_pkg::result_t  result_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_FETCH
  } state_e;

  state_e                               state_q;
  logic [rllt_pkg::BCNT_W-1:0]          byte_count_q;
  logic [rllt_pkg::RCNT_W-1:0]          run_count_q;
  logic [rllt_pkg::LINE_BITS-1:0]       last_line_q;
  logic [rllt_pkg::IDX_W-1:0]           lo_q, hi_q, mid_q;
  logic [rllt_pkg::OFF_W-1:0]           offset_q;
  logic                                 valid_q;
  rllt_pkg::result_t                    result_q;

  rllt_pkg::run_t                       run_mem [rllt_pkg::RUN_DEPTH];
  rllt_pkg::run_t                       rd_q;
  logic                                 rd_en;
  logic [rllt_pkg::IDX_W-1:0]           rd_addr;
  logic                                 wr_en;
  rllt_pkg::run_t                       wr_data;

  logic                                 accept;
  logic [rllt_pkg::LINE_BITS-1:0]       in_line;
  logic                                 same_line;
  logic                                 code_full;
  logic                                 run_full;
  logic [rllt_pkg::IDX_W-1:0]           hi_init;
  logic [rllt_pkg::IDX_W-1:0]           mid_init;
  logic                                 go_right;
  logic [rllt_pkg::IDX_W-1:0]           lo_n, hi_n, mid_n;
  logic [rllt_pkg::IDX_W:0]             span_n, span_init;

  assign accept    = start && !busy;
  assign in_line   = rllt_pkg::LINE_BITS'(item_i.source_line);
  assign same_line = (run_count_q != '0) && (last_line_q == in_line);
  assign code_full = byte_count_q >= rllt_pkg::BCNT_W'(rllt_pkg::CODE_DEPTH);
  assign run_full  = run_count_q >= rllt_pkg::RCNT_W'(rllt_pkg::RUN_DEPTH);
  assign wr_en     = accept && (item_i.op == rllt_pkg::OP_APPEND) && !code_full
                     && !same_line && !run_full;
  assign wr_data   = '{start: rllt_pkg::OFF_W'(byte_count_q), line: in_line};

  assign hi_init   = rllt_pkg::IDX_W'(run_count_q - rllt_pkg::RCNT_W'(1));
  assign span_init = {1'b0, hi_init} + (rllt_pkg::IDX_W + 1)'(1);
  assign mid_init  = rllt_pkg::IDX_W'(span_init >> 1);

  assign go_right  = rd_q.start <= offset_q;
  assign lo_n      = go_right ? mid_q : lo_q;
  assign hi_n      = go_right ? hi_q : mid_q - rllt_pkg::IDX_W'(1);
  assign span_n    = {1'b0, hi_n} - {1'b0, lo_n} + (rllt_pkg::IDX_W + 1)'(1);
  assign mid_n     = lo_n + rllt_pkg::IDX_W'(span_n >> 1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = lo_n;
    unique case (state_q)
      S_IDLE: begin
        rd_en   = accept && (item_i.op == rllt_pkg::OP_LOOKUP) && (run_count_q != '0);
        rd_addr = (hi_init == '0) ? '0 : mid_init;
      end
      S_PROBE: begin
        rd_en   = 1'b1;
        rd_addr = (lo_n == hi_n) ? lo_n : mid_n;
      end
      S_FETCH: begin
        rd_en   = 1'b0;
        rd_addr = lo_n;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = lo_n;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      run_mem[rllt_pkg::IDX_W'(run_count_q)] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= run_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      byte_count_q <= '0;
      run_count_q  <= '0;
      last_line_q  <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      mid_q        <= '0;
      offset_q     <= '0;
      valid_q      <= 1'b0;
      result_q     <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (item_i.op == rllt_pkg::OP_APPEND) begin
              valid_q <= 1'b1;
              priority if (code_full) begin
                result_q <= '{found_line: '0, status: rllt_pkg::ST_FULL};
              end else if (same_line) begin
                result_q     <= '{found_line: '0, status: rllt_pkg::ST_OK};
                byte_count_q <= byte_count_q + rllt_pkg::BCNT_W'(1);
              end else if (run_full) begin
                result_q <= '{found_line: '0, status: rllt_pkg::ST_FULL};
              end else begin
                result_q     <= '{found_line: '0, status: rllt_pkg::ST_OK};
                run_count_q  <= run_count_q + rllt_pkg::RCNT_W'(1);
                byte_count_q <= byte_count_q + rllt_pkg::BCNT_W'(1);
                last_line_q  <= in_line;
              end
            end else if (run_count_q == '0) begin
              valid_q  <= 1'b1;
              result_q <= '{found_line: '0, status: rllt_pkg::ST_EMPTY};
            end else begin
              offset_q <= rllt_pkg::OFF_W'(item_i.code_offset);
              lo_q     <= '0;
              hi_q     <= hi_init;
              mid_q    <= mid_init;
              state_q  <= (hi_init == '0) ? S_FETCH : S_PROBE;
            end
          end
        end
        S_PROBE: begin
          lo_q  <= lo_n;
          hi_q  <= hi_n;
          mid_q <= mid_n;
          if (lo_n == hi_n) begin
            state_q <= S_FETCH;
          end
        end
        S_FETCH: begin
          valid_q  <= 1'b1;
          result_q <= '{found_line: 16'(rd_q.line), status: rllt_pkg::ST_OK};
          state_q  <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = state_q != S_IDLE;
  assign result_valid_o = valid_q;
  assign result_o       = result_q;

  a_run_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_count_q <= rllt_pkg::RCNT_W'(rllt_pkg::RUN_DEPTH))
    else $error("run count beyond table depth");

  a_runs_within_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rllt_pkg::BCNT_W'(run_count_q) <= byte_count_q)
    else $error("more runs than code bytes");

  a_run_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_count_q != $past(run_count_q)) |->
      (run_count_q == $past(run_count_q) + rllt_pkg::RCNT_W'(1)))
    else $error("run count moved by other than one");

  a_probe_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (lo_q < hi_q) && (mid_q > lo_q) && (mid_q <= hi_q))
    else $error("search window collapsed while probing");

  a_error_line_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (result_q.status != rllt_pkg::ST_OK)) |-> (result_q.found_line == '0))
    else $error("error result carries a line");

endmodule
`default_nettype wire
